### sv/hrp_pkg.sv
// Shared types, constants and the digit decode for the hex record parser.
// Used by hrp_front, hrp_queue, hrp_back and hex_record_parser_top.
package hrp_pkg;

  localparam logic [7:0] COLON_CHAR   = 8'h3A;
  localparam logic [7:0] LAST_DIGIT   = 8'h39;
  localparam logic [7:0] DIGIT_MASK   = 8'h3F;
  localparam logic [7:0] ALPHA_MASK   = 8'h47;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ALPHA_BIAS   = 8'h37;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'hFF;
  localparam int         QUEUE_DEPTH_DEF  = 2;

  // register index of max_length in the configuration space
  localparam logic       REG_MAX_LENGTH = 1'b0;

  // one classified character, as it travels from front to back
  typedef struct packed {
    logic       is_colon;
    logic [7:0] nib;
  } item_t;

  // one result, as built by the back end
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic        record_done;
    logic        checksum_ok;
    logic        too_long;
    logic [7:0]  record_length;
    logic [15:0] record_offset;
    logic [7:0]  record_type;
  } result_t;

  // Unchecked hex digit value; non-digits give whatever the formula gives.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= LAST_DIGIT) begin
      v = (c & DIGIT_MASK) - ASCII_ZERO;
    end else begin
      v = (c & ALPHA_MASK) - ALPHA_BIAS;
    end
    return v;
  endfunction

endpackage

### sv/hrp_front.sv
// Front end of the hex record parser: takes characters and classifies them.
// Depends on hrp_pkg; feeds hrp_queue.
module hrp_front (
  input  logic          in_valid,
  input  logic [7:0]    char_in,
  input  logic          q_full,
  output logic          in_stall,
  output logic          q_push,
  output hrp_pkg::item_t q_item
);
  import hrp_pkg::*;

  // hold the sender while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.is_colon = (char_in == COLON_CHAR);
    q_item.nib      = digit_value(char_in);
  end

endmodule

### sv/hrp_queue.sv
// Short FIFO of classified characters between front and back end.
// Depends on hrp_pkg for the item type.
module hrp_queue #(
  parameter int QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hrp_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output hrp_pkg::item_t head_item
);
  import hrp_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  item_t           entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/hrp_back.sv
// Back end of the hex record parser: record state machine and output register.
// Depends on hrp_pkg; pops hrp_queue.
module hrp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hrp_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic [7:0]       max_length,
  output logic             out_valid,
  input  logic             out_stall,
  output hrp_pkg::result_t result
);
  import hrp_pkg::*;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_LEN0  = 4'd1;
  localparam logic [3:0] PH_LEN1  = 4'd2;
  localparam logic [3:0] PH_OFF0  = 4'd3;
  localparam logic [3:0] PH_OFF1  = 4'd4;
  localparam logic [3:0] PH_OFF2  = 4'd5;
  localparam logic [3:0] PH_OFF3  = 4'd6;
  localparam logic [3:0] PH_TYP0  = 4'd7;
  localparam logic [3:0] PH_TYP1  = 4'd8;
  localparam logic [3:0] PH_DATA  = 4'd9;
  localparam logic [3:0] PH_CKS0  = 4'd10;
  localparam logic [3:0] PH_CKS1  = 4'd11;
  localparam logic [3:0] PH_DONE  = 4'd12;
  localparam logic [3:0] PH_LONG  = 4'd13;

  logic [3:0]  phase, phase_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [15:0] offset_reg, offset_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  checksum_byte, checksum_byte_next;
  logic [7:0]  partial_byte, partial_byte_next;
  logic [7:0]  byte_count, byte_count_next;
  logic        high_nibble_next, high_nibble_next_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        verdict_ok, verdict_ok_next;
  logic [7:0]  total;
  result_t     res_next;

  // advance when the output register is free or being taken
  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    phase_next            = phase;
    length_reg_next       = length_reg;
    offset_reg_next       = offset_reg;
    type_reg_next         = type_reg;
    checksum_byte_next    = checksum_byte;
    partial_byte_next     = partial_byte;
    byte_count_next       = byte_count;
    high_nibble_next_next = high_nibble_next;
    running_sum_next      = running_sum;
    verdict_ok_next       = verdict_ok;
    total                 = '0;
    res_next              = '0;

    if (q_item.is_colon) begin
      phase_next            = PH_LEN0;
      byte_count_next       = '0;
      high_nibble_next_next = 1'b1;
      running_sum_next      = '0;
      verdict_ok_next       = 1'b0;
    end else begin
      case (phase)
        PH_LEN0, PH_LEN1: begin
          length_reg_next = {length_reg[3:0], 4'b0} + q_item.nib;
          phase_next      = phase + 4'd1;
          if (phase == PH_LEN1 && length_reg_next > max_length) begin
            phase_next           = PH_LONG;
            res_next.record_done = 1'b1;
            res_next.too_long    = 1'b1;
          end
        end
        PH_OFF0, PH_OFF1, PH_OFF2, PH_OFF3: begin
          offset_reg_next = {offset_reg[11:0], 4'b0} + {8'b0, q_item.nib};
          phase_next      = phase + 4'd1;
        end
        PH_TYP0, PH_TYP1: begin
          type_reg_next = {type_reg[3:0], 4'b0} + q_item.nib;
          phase_next    = phase + 4'd1;
          // empty record: skip straight to the checksum digits
          if (phase == PH_TYP1 && length_reg == '0) begin
            phase_next = PH_CKS0;
          end
        end
        PH_DATA: begin
          partial_byte_next     = {partial_byte[3:0], 4'b0} + q_item.nib;
          high_nibble_next_next = !high_nibble_next;
          if (!high_nibble_next) begin
            res_next.data_valid = 1'b1;
            res_next.data_byte  = partial_byte_next;
            res_next.data_index = byte_count;
            running_sum_next    = running_sum + partial_byte_next;
            byte_count_next     = byte_count + 8'd1;
            if (byte_count_next == length_reg) begin
              phase_next = PH_CKS0;
            end
          end
        end
        PH_CKS0, PH_CKS1: begin
          checksum_byte_next = {checksum_byte[3:0], 4'b0} + q_item.nib;
          phase_next         = phase + 4'd1;
          if (phase == PH_CKS1) begin
            total = running_sum + length_reg + type_reg + checksum_byte_next
                  + offset_reg[15:8] + offset_reg[7:0];
            verdict_ok_next      = (total == '0);
            res_next.record_done = 1'b1;
            phase_next           = PH_DONE;
          end
        end
        default: begin
          // idle, finished or unused phase: drop the character
        end
      endcase
    end

    res_next.checksum_ok   = verdict_ok_next;
    res_next.record_length = length_reg_next;
    res_next.record_offset = offset_reg_next;
    res_next.record_type   = type_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      length_reg       <= '0;
      offset_reg       <= '0;
      type_reg         <= '0;
      checksum_byte    <= '0;
      partial_byte     <= '0;
      byte_count       <= '0;
      high_nibble_next <= 1'b1;
      running_sum      <= '0;
      verdict_ok       <= 1'b0;
    end else if (q_pop) begin
      phase            <= phase_next;
      length_reg       <= length_reg_next;
      offset_reg       <= offset_reg_next;
      type_reg         <= type_reg_next;
      checksum_byte    <= checksum_byte_next;
      partial_byte     <= partial_byte_next;
      byte_count       <= byte_count_next;
      high_nibble_next <= high_nibble_next_next;
      running_sum      <= running_sum_next;
      verdict_ok       <= verdict_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= res_next;
    end
  end

endmodule

### sv/hex_record_parser_top.sv
// Top level of the hex record parser: config register, front, queue, back.
// Depends on hrp_pkg, hrp_front, hrp_queue and hrp_back.
//
// Usage:
//   Input channel (in_valid, in_stall, char_in) carries one ASCII character
//   per transfer. A colon starts or restarts a record; the length, offset,
//   type, data and checksum digits follow. Characters outside a record are
//   dropped but still produce a result.
//   Output channel (out_valid, out_stall, result fields) carries exactly one
//   result per accepted character, in order: a completed data byte with its
//   index, the end-of-record flag with the checksum verdict or the too-long
//   flag, and the current length, offset and type.
//   A transfer writes the character into the queue; the back end pops it
//   from there and loads its result into the output register.
//   Throughput: one character per cycle while out_stall is low; the
//   front end pushes into a QUEUE_DEPTH-entry queue and the back end
//   updates the record state and loads the output register per character.
//   When the receiver stalls, the output register holds its result; the
//   queue fills behind it and in_stall rises once it is full.
//   Reset: phase goes idle, registers clear, max_length returns to 255 and
//   the queue and output register empty. No clearing pass is needed.
//   Config: max_length at byte address 0 of the APB port; write while idle.
module hex_record_parser_top #(
  parameter int QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [7:0]  data_index,
  output logic        record_done,
  output logic        checksum_ok,
  output logic        too_long,
  output logic [7:0]  record_length,
  output logic [15:0] record_offset,
  output logic [7:0]  record_type
);
  import hrp_pkg::*;

  logic       [7:0] max_length;
  logic             cfg_write;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  item_t            push_item;
  item_t            head_item;
  result_t          result;

  // APB: always ready, one register at word index zero
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write && paddr[2] == REG_MAX_LENGTH) begin
      max_length <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_LENGTH) ? {24'b0, max_length} : '0;

  // classify each character on the way in
  hrp_front u_front (
    .in_valid (in_valid),
    .char_in  (char_in),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // decouple front from back so each side can stall on its own
  hrp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  // record state machine and output register
  hrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .max_length (max_length),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign data_valid    = result.data_valid;
  assign data_byte     = result.data_byte;
  assign data_index    = result.data_index;
  assign record_done   = result.record_done;
  assign checksum_ok   = result.checksum_ok;
  assign too_long      = result.too_long;
  assign record_length = result.record_length;
  assign record_offset = result.record_offset;
  assign record_type   = result.record_type;

  // a length error always ends the record and never passes the checksum
  a_too_long_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_long) |-> (record_done && !checksum_ok))
    else $error("too_long without record_done or with checksum_ok");

  // a data byte and the end of a record never come on the same character
  a_data_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(data_valid && record_done))
    else $error("data byte and record end on one result");

  // a data byte always lies inside the declared length
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_valid) |-> (data_index < record_length))
    else $error("data_index beyond record_length");

  // the input is only held back while the queue is full
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

### tb/hex_record_parser_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hex_record_parser_top: streams hex text, predicts every result.
// Depends on hrp_pkg and hex_record_parser_top; needs no files or arguments.
module hex_record_parser_top_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int BATCHES     = 16;
  localparam int BATCH_CHARS = 125;

  localparam logic [2:0] MAX_LENGTH_ADDR = {hrp_pkg::REG_MAX_LENGTH, 2'b00};

  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_LOWER_A = "a";

  // where the parser stands inside a record
  typedef enum logic [3:0] {
    P_IDLE, P_LEN1, P_LEN2, P_OFS1, P_OFS2, P_OFS3, P_OFS4,
    P_TYPE1, P_TYPE2, P_DATA, P_SUM1, P_SUM2, P_DONE, P_OVER
  } parse_phase_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  char_in  = '0;
  logic        out_stall = 1'b0;

  logic [31:0] prdata;
  logic        pready;
  logic        in_stall;
  logic        out_valid;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [7:0]  data_index;
  logic        record_done;
  logic        checksum_ok;
  logic        too_long;
  logic [7:0]  record_length;
  logic [15:0] record_offset;
  logic [7:0]  record_type;

  hex_record_parser_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .char_in(char_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .data_valid(data_valid), .data_byte(data_byte), .data_index(data_index),
    .record_done(record_done), .checksum_ok(checksum_ok), .too_long(too_long),
    .record_length(record_length), .record_offset(record_offset),
    .record_type(record_type)
  );

  always #4 clk = ~clk;

  // Parser state as this bench tracks it, plus its copy of max_length.
  parse_phase_t st_phase     = P_IDLE;
  logic [7:0]   st_len       = '0;
  logic [15:0]  st_ofs       = '0;
  logic [7:0]   st_type      = '0;
  logic [7:0]   st_cksum     = '0;
  logic [7:0]   st_partial   = '0;
  logic [7:0]   st_count     = '0;
  logic         st_high_next = 1'b1;
  logic [7:0]   st_sum       = '0;
  logic         st_verdict   = 1'b0;
  logic [7:0]   cfg_max_length = hrp_pkg::MAX_LENGTH_RESET;

  // results still owed by the block, oldest first
  hrp_pkg::result_t expected_results[$];

  // text of the record being built for transfer
  logic [7:0] record_text[$];

  int error_count = 0;
  int chars_sent  = 0;
  int cycle_count = 0;

  // idle knobs, switched per phase of the run
  bit sender_gaps     = 1'b0;
  bit receiver_stalls = 1'b0;

  function automatic void note_failure(input string msg);
    error_count++;
    $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got)
      note_failure($sformatf("%s mismatch, expected %0h, got %0h", name, want, got));
  endfunction

  // Value of one digit character; no validity check, non-hex gives what the formula gives.
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    return (c <= hrp_pkg::LAST_DIGIT) ? (c & hrp_pkg::DIGIT_MASK) - hrp_pkg::ASCII_ZERO
                                      : (c & hrp_pkg::ALPHA_MASK) - hrp_pkg::ALPHA_BIAS;
  endfunction

  // Advance the tracked parser by one character and queue the result it owes.
  function automatic void predict_char(input logic [7:0] c);
    hrp_pkg::result_t r;
    logic [7:0] nib;
    logic [7:0] total;
    r = '0;
    if (c == hrp_pkg::COLON_CHAR) begin
      // restart: header registers keep their bits until shifted out
      st_phase     = P_LEN1;
      st_count     = '0;
      st_high_next = 1'b1;
      st_sum       = '0;
      st_verdict   = 1'b0;
    end else begin
      nib = digit_of(c);
      case (st_phase)
        P_LEN1: begin
          st_len   = {st_len[3:0], 4'h0} + nib;
          st_phase = P_LEN2;
        end
        P_LEN2: begin
          st_len = {st_len[3:0], 4'h0} + nib;
          if (st_len > cfg_max_length) begin
            // length over the limit ends the record right here
            st_phase      = P_OVER;
            r.record_done = 1'b1;
            r.too_long    = 1'b1;
          end else begin
            st_phase = P_OFS1;
          end
        end
        P_OFS1, P_OFS2, P_OFS3, P_OFS4: begin
          st_ofs   = {st_ofs[11:0], 4'h0} + 16'(nib);
          st_phase = parse_phase_t'(st_phase + 4'd1);
        end
        P_TYPE1: begin
          st_type  = {st_type[3:0], 4'h0} + nib;
          st_phase = P_TYPE2;
        end
        P_TYPE2: begin
          st_type = {st_type[3:0], 4'h0} + nib;
          // a zero-length record skips straight to its checksum
          st_phase = (st_len == 8'd0) ? P_SUM1 : P_DATA;
        end
        P_DATA: begin
          st_partial   = {st_partial[3:0], 4'h0} + nib;
          st_high_next = !st_high_next;
          if (st_high_next) begin
            r.data_valid = 1'b1;
            r.data_byte  = st_partial;
            r.data_index = st_count;
            st_sum   = st_sum + st_partial;
            st_count = st_count + 8'd1;
            if (st_count == st_len) st_phase = P_SUM1;
          end
        end
        P_SUM1: begin
          st_cksum = {st_cksum[3:0], 4'h0} + nib;
          st_phase = P_SUM2;
        end
        P_SUM2: begin
          st_cksum   = {st_cksum[3:0], 4'h0} + nib;
          total      = st_sum + st_len + st_type + st_cksum + st_ofs[15:8] + st_ofs[7:0];
          st_verdict = (total == 8'd0);
          st_phase   = P_DONE;
          r.record_done = 1'b1;
        end
        default: begin
          // idle or finished: drop the character
        end
      endcase
    end
    r.checksum_ok   = st_verdict;
    r.record_length = st_len;
    r.record_offset = st_ofs;
    r.record_type   = st_type;
    expected_results.push_back(r);
  endfunction

  // Idle length: mostly short, now and then a long one.
  function automatic int pick_idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    record_text.push_back(hex_digit(b[7:4]));
    record_text.push_back(hex_digit(b[3:0]));
  endfunction

  // Build a complete record with random data; corrupt the checksum on request.
  function automatic void build_record(input logic [7:0] len, input logic [15:0] ofs,
                                       input logic [7:0] rtype, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    record_text.delete();
    record_text.push_back(hrp_pkg::COLON_CHAR);
    add_byte(len);
    add_byte(ofs[15:8]);
    add_byte(ofs[7:0]);
    add_byte(rtype);
    sum = len + ofs[15:8] + ofs[7:0] + rtype;
    for (i = 0; i < len; i++) begin
      b   = 8'($urandom);
      sum = sum + b;
      add_byte(b);
    end
    b = 8'd0 - sum;
    if (bad_sum) b = b + 8'($urandom_range(1, 255));
    add_byte(b);
  endfunction

  // Receiver side: random stall runs, mixed with runs of no stall at all.
  int stall_run = 0;
  bit stall_now = 1'b0;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_now = receiver_stalls && ($urandom_range(0, 2) == 0);
      stall_run = stall_now ? pick_idle_len() : $urandom_range(1, 12);
    end
    stall_run = stall_run - 1;
    out_stall <= stall_now;
  end

  // Check every result transfer against the oldest owed result.
  always @(posedge clk) begin
    hrp_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_failure("result transfer with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("data_valid", 32'(want.data_valid), 32'(data_valid));
        check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
        check_field("data_index", 32'(want.data_index), 32'(data_index));
        check_field("record_done", 32'(want.record_done), 32'(record_done));
        check_field("checksum_ok", 32'(want.checksum_ok), 32'(checksum_ok));
        check_field("too_long", 32'(want.too_long), 32'(too_long));
        check_field("record_length", 32'(want.record_length), 32'(record_length));
        check_field("record_offset", 32'(want.record_offset), 32'(record_offset));
        check_field("record_type", 32'(want.record_type), 32'(record_type));
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Transfer one character: optional gap, then hold it until accepted.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    predict_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_record_text();
    int i;
    for (i = 0; i < record_text.size(); i++) send_char(record_text[i]);
  endtask

  // Drop valid and hold until every owed result has been seen.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write max_length while the parser is idle, then read it back.
  task automatic set_max_length(input logic [7:0] value);
    logic [31:0] wdata;
    logic [31:0] readback;
    wait_for_results();
    wdata      = $urandom;
    wdata[7:0] = value;
    apb_write(MAX_LENGTH_ADDR, wdata);
    cfg_max_length = value;
    apb_read(MAX_LENGTH_ADDR, readback);
    check_field("max_length readback", 32'(value), 32'(readback[7:0]));
  endtask

  task automatic test_register_access();
    logic [31:0] readback;
    apb_read(MAX_LENGTH_ADDR, readback);
    check_field("max_length after reset", 32'(hrp_pkg::MAX_LENGTH_RESET),
                32'(readback[7:0]));
    set_max_length(8'h00);
    set_max_length(8'h5A);
    set_max_length(8'hFF);
  endtask

  // Short directed records: noise, restart, zero length, field extremes.
  task automatic test_record_basics();
    send_char("Z");                 // outside any record: dropped
    send_text(":0");                // cut short by the next colon
    send_text(":00000001FF");       // end-of-file record, zero length, good sum
    send_char(8'hFF);               // after the record: dropped
    send_text(":01FFFF00ff02");     // top offset, top data byte, lowercase digits
  endtask

  // Length limit at both extremes, non-hex digits, and the longest record.
  task automatic test_length_limit();
    set_max_length(8'h00);
    send_text(":0000000000");       // zero length still fits a limit of zero
    send_text(":01");               // one byte is too long
    send_char("q");                 // after a too-long end: dropped
    send_char(hrp_pkg::COLON_CHAR);
    send_char(8'h00);               // non-hex length digits
    send_char(8'hFF);
    set_max_length(8'hFE);
    send_text(":FF");               // just over the limit
    set_max_length(8'hFF);
    build_record(8'hFF, 16'($urandom), 8'h00, 1'b0);
    send_record_text();
  endtask

  // One random record or burst of noise; mostly well formed.
  task automatic send_random_record();
    int kind;
    int r;
    int len;
    int keep;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 15) len = 0;
    else if (r < 75) len = $urandom_range(1, 6);
    else if (r < 90) len = $urandom_range(7, 24);
    else if (r < 96 && cfg_max_length < 8'hFF) len = cfg_max_length + 1;
    else len = (cfg_max_length <= 8'd24) ? cfg_max_length : $urandom_range(0, 24);
    build_record(8'(len), 16'($urandom),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
                 $urandom_range(0, 7) == 0);
    if (kind < 18) begin
      // stray byte anywhere after the colon, a colon included
      record_text[$urandom_range(1, record_text.size() - 1)] = 8'($urandom);
    end else if (kind < 26) begin
      keep = $urandom_range(1, record_text.size() - 1);
      while (record_text.size() > keep) void'(record_text.pop_back());
    end
    if (len > cfg_max_length && $urandom_range(0, 1) == 1) begin
      // the rest would be dropped anyway
      while (record_text.size() > 3) void'(record_text.pop_back());
    end
    send_record_text();
  endtask

  // Batches of random records, each under a fresh limit and idle mix.
  task automatic test_random_stream();
    int batch;
    int r;
    int start;
    logic [7:0] limit;
    for (batch = 0; batch < BATCHES; batch++) begin
      r = $urandom_range(0, 3);
      if (batch == 0) limit = 8'h00;
      else if (batch == 1) limit = 8'hFF;
      else if (r == 0) limit = 8'($urandom);
      else if (r == 1) limit = 8'($urandom_range(1, 8));
      else if (r == 2) limit = 8'hFF;
      else limit = 8'h00;
      set_max_length(limit);
      // one batch runs flat out on both sides
      sender_gaps     = (batch != 1) && ($urandom_range(0, 3) != 0);
      receiver_stalls = (batch != 1) && ($urandom_range(0, 3) != 0);
      start = chars_sent;
      while (chars_sent - start < BATCH_CHARS) send_random_record();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    test_record_basics();
    test_length_limit();
    test_random_stream();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
sv/hrp_pkg.sv
sv/hrp_front.sv
sv/hrp_queue.sv
sv/hrp_back.sv
sv/hex_record_parser_top.sv
tb/hex_record_parser_top_tb.sv
